// File: hdl/rect_subtract_bands_macros.svh
// Assertion macros for the rectangle band splitter.
`ifndef RECT_SUBTRACT_BANDS_MACROS_SVH
`define RECT_SUBTRACT_BANDS_MACROS_SVH

`ifndef SYNTHESIS
`define RSB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsb assertion failed");
`define RSB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsb assertion failed");
`else
`define RSB_ASSERT_SAME(label, ante, cons)
`define RSB_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hdl/rsb_pkg.sv
package rsb_pkg;

  localparam int NUM_PIECES   = 4;
  localparam int PIECE_TOP    = 0;
  localparam int PIECE_LEFT   = 1;
  localparam int PIECE_RIGHT  = 2;
  localparam int PIECE_BOTTOM = 3;

  typedef logic [NUM_PIECES-1:0] piece_mask_t;

  typedef struct packed {
    logic        valid;
    piece_mask_t mask;
  } rsb_ctrl_t;

endpackage

// File: hdl/rsb_bands.sv
module rsb_bands #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] base_left,
  input  logic signed [COORD_BITS-1:0] base_top,
  input  logic signed [COORD_BITS-1:0] base_right,
  input  logic signed [COORD_BITS-1:0] base_bottom,
  input  logic signed [COORD_BITS-1:0] cut_left,
  input  logic signed [COORD_BITS-1:0] cut_top,
  input  logic signed [COORD_BITS-1:0] cut_right,
  input  logic signed [COORD_BITS-1:0] cut_bottom,
  output rsb_pkg::rsb_ctrl_t           ctrl,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] g_left,
  output logic signed [COORD_BITS-1:0] g_top,
  output logic signed [COORD_BITS-1:0] g_right,
  output logic signed [COORD_BITS-1:0] g_bottom,
  output logic signed [COORD_BITS-1:0] g_end1,
  output logic signed [COORD_BITS-1:0] g_end2,
  output logic signed [COORD_BITS-1:0] g_row1,
  output logic signed [COORD_BITS-1:0] g_row2,
  output logic signed [COORD_BITS-1:0] g_cut_l,
  output logic signed [COORD_BITS-1:0] g_cut_r
);

  localparam int CB = COORD_BITS;

  logic rdy_a, rdy_b, rdy_c;

  // stage A
  logic                 va_r;
  logic signed [CB-1:0] a_bl_r, a_bt_r, a_br_r, a_bb_r, a_cl_r, a_cr_r;
  logic signed [CB-1:0] a_end1_r, a_end2_r;
  logic                 a_top_hit_r, a_wide_r;

  // stage B
  logic                 vb_r;
  logic signed [CB-1:0] b_bl_r, b_bt_r, b_br_r, b_bb_r, b_end1_r, b_end2_r, b_row1_r;
  logic signed [CB-1:0] b_l_r, b_r_r;
  logic                 b_top_ok_r, b_left_pre_r, b_right_pre_r, b_wide_r;

  // stage C
  logic                 vc_r;
  logic signed [CB-1:0] c_bl_r, c_bt_r, c_br_r, c_bb_r, c_end1_r, c_end2_r;
  logic signed [CB-1:0] c_row1_r, c_row2_r, c_l_r, c_r_r;
  rsb_pkg::piece_mask_t c_mask_r;

  logic signed [CB-1:0] end1_a, end2_a, r_b, l_b;
  logic                 mid_hit_c, bot_c;

  assign rdy_c    = !vc_r || out_ready;
  assign rdy_b    = !vb_r || rdy_c;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  assign end1_a = (cut_top < base_bottom) ? cut_top : base_bottom;
  assign end2_a = (cut_bottom < base_bottom) ? cut_bottom : base_bottom;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (rdy_a) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      a_bl_r      <= base_left;
      a_bt_r      <= base_top;
      a_br_r      <= base_right;
      a_bb_r      <= base_bottom;
      a_cl_r      <= cut_left;
      a_cr_r      <= cut_right;
      a_end1_r    <= end1_a;
      a_end2_r    <= end2_a;
      a_top_hit_r <= base_top < end1_a;
      a_wide_r    <= base_left < base_right;
    end
  end

  assign r_b = (a_cl_r < a_br_r) ? a_cl_r : a_br_r;
  assign l_b = (a_cr_r > a_bl_r) ? a_cr_r : a_bl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (rdy_b) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && va_r) begin
      b_bl_r        <= a_bl_r;
      b_bt_r        <= a_bt_r;
      b_br_r        <= a_br_r;
      b_bb_r        <= a_bb_r;
      b_end1_r      <= a_end1_r;
      b_end2_r      <= a_end2_r;
      b_row1_r      <= a_top_hit_r ? a_end1_r : a_bt_r;
      b_l_r         <= l_b;
      b_r_r         <= r_b;
      b_top_ok_r    <= a_top_hit_r && a_wide_r;
      b_left_pre_r  <= a_wide_r && (a_bl_r < a_cl_r);
      b_right_pre_r <= a_wide_r && (a_cr_r < a_br_r);
      b_wide_r      <= a_wide_r;
    end
  end

  assign mid_hit_c = b_row1_r < b_end2_r;
  assign bot_c     = b_wide_r && (mid_hit_c ? (b_end2_r < b_bb_r) : (b_row1_r < b_bb_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (rdy_c) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && vb_r) begin
      c_bl_r   <= b_bl_r;
      c_bt_r   <= b_bt_r;
      c_br_r   <= b_br_r;
      c_bb_r   <= b_bb_r;
      c_end1_r <= b_end1_r;
      c_end2_r <= b_end2_r;
      c_row1_r <= b_row1_r;
      c_row2_r <= mid_hit_c ? b_end2_r : b_row1_r;
      c_l_r    <= b_l_r;
      c_r_r    <= b_r_r;
      c_mask_r[rsb_pkg::PIECE_TOP]    <= b_top_ok_r;
      c_mask_r[rsb_pkg::PIECE_LEFT]   <= mid_hit_c && b_left_pre_r;
      c_mask_r[rsb_pkg::PIECE_RIGHT]  <= mid_hit_c && b_right_pre_r;
      c_mask_r[rsb_pkg::PIECE_BOTTOM] <= bot_c;
    end
  end

  assign ctrl.valid = vc_r;
  assign ctrl.mask  = c_mask_r;
  assign g_left     = c_bl_r;
  assign g_top      = c_bt_r;
  assign g_right    = c_br_r;
  assign g_bottom   = c_bb_r;
  assign g_end1     = c_end1_r;
  assign g_end2     = c_end2_r;
  assign g_row1     = c_row1_r;
  assign g_row2     = c_row2_r;
  assign g_cut_l    = c_l_r;
  assign g_cut_r    = c_r_r;

endmodule

// File: hdl/rsb_emit.sv
module rsb_emit #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rsb_pkg::rsb_ctrl_t           ctrl,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] g_left,
  input  logic signed [COORD_BITS-1:0] g_top,
  input  logic signed [COORD_BITS-1:0] g_right,
  input  logic signed [COORD_BITS-1:0] g_bottom,
  input  logic signed [COORD_BITS-1:0] g_end1,
  input  logic signed [COORD_BITS-1:0] g_end2,
  input  logic signed [COORD_BITS-1:0] g_row1,
  input  logic signed [COORD_BITS-1:0] g_row2,
  input  logic signed [COORD_BITS-1:0] g_cut_l,
  input  logic signed [COORD_BITS-1:0] g_cut_r,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] piece_left,
  output logic signed [COORD_BITS-1:0] piece_top,
  output logic signed [COORD_BITS-1:0] piece_right,
  output logic signed [COORD_BITS-1:0] piece_bottom,
  output logic                         piece_last
);

  localparam int CB = COORD_BITS;

  rsb_pkg::piece_mask_t mask_r, mask_nxt, sel, mask_rest;
  logic signed [CB-1:0] h_bl_r, h_bt_r, h_br_r, h_bb_r, h_end1_r, h_end2_r;
  logic signed [CB-1:0] h_row1_r, h_row2_r, h_l_r, h_r_r;
  logic                 load, take;

  logic                 ov_r, ov_nxt;
  logic signed [CB-1:0] ol_r, ot_r, or_r, ob_r;
  logic signed [CB-1:0] ol_nxt, ot_nxt, or_nxt, ob_nxt;
  logic                 olast_r;

  assign sel       = mask_r & (~mask_r + rsb_pkg::piece_mask_t'(1));
  assign mask_rest = mask_r & ~sel;
  assign load      = (|mask_r) && (!ov_r || out_ready);
  assign in_ready  = !(|mask_r) || (load && !(|mask_rest));
  assign take      = ctrl.valid && in_ready;

  always_comb begin
    if (take) begin
      mask_nxt = ctrl.mask;
    end else if (load) begin
      mask_nxt = mask_rest;
    end else begin
      mask_nxt = mask_r;
    end
  end

  always_comb begin
    ol_nxt = h_bl_r;
    ot_nxt = h_bt_r;
    or_nxt = h_br_r;
    ob_nxt = h_end1_r;
    if (sel[rsb_pkg::PIECE_LEFT]) begin
      ot_nxt = h_row1_r;
      or_nxt = h_r_r;
      ob_nxt = h_end2_r;
    end else if (sel[rsb_pkg::PIECE_RIGHT]) begin
      ol_nxt = h_l_r;
      ot_nxt = h_row1_r;
      ob_nxt = h_end2_r;
    end else if (sel[rsb_pkg::PIECE_BOTTOM]) begin
      ot_nxt = h_row2_r;
      ob_nxt = h_bb_r;
    end
  end

  always_comb begin
    if (load) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      h_bl_r   <= g_left;
      h_bt_r   <= g_top;
      h_br_r   <= g_right;
      h_bb_r   <= g_bottom;
      h_end1_r <= g_end1;
      h_end2_r <= g_end2;
      h_row1_r <= g_row1;
      h_row2_r <= g_row2;
      h_l_r    <= g_cut_l;
      h_r_r    <= g_cut_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ol_r    <= ol_nxt;
      ot_r    <= ot_nxt;
      or_r    <= or_nxt;
      ob_r    <= ob_nxt;
      olast_r <= !(|mask_rest);
    end
  end

  assign out_valid    = ov_r;
  assign piece_left   = ol_r;
  assign piece_top    = ot_r;
  assign piece_right  = or_r;
  assign piece_bottom = ob_r;
  assign piece_last   = olast_r;

endmodule

// File: hdl/rect_subtract_bands.sv
// Rectangle difference: base minus cut-out, as up to four band pieces.
// Input channel in_*: one transaction carries a base and a cut-out rectangle,
// half-open (left/top inclusive, right/bottom exclusive), signed coordinates.
// Output channel out_*: one transaction per non-empty piece, in the order top
// band, middle-left, middle-right, bottom band; out_tlast marks the last piece
// of an input. An input with an empty result produces no output transaction.
// Each input passes through three compare/select register stages, which feed a
// piece serializer that drives the output register one piece per cycle while
// the receiver accepts pieces.
// Throughput: one input per cycle when each input yields at most one piece and
// the receiver accepts pieces; an input with more pieces holds the serializer
// until its last piece loads, so the worst case is an input with all four pieces.
// The serializer takes the next input in the same cycle its last piece loads,
// so pieces of consecutive inputs stream without gaps.
// Reset (rst_n low, synchronous) empties the pipeline and the output register.
// When the receiver holds out_tready low, the output holds and the stall backs
// up stage by stage; bubbles still collapse, and in_tready drops only when
// every stage is full.
`include "rect_subtract_bands_macros.svh"

module rect_subtract_bands #(
  parameter int COORD_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // base_left, base_top, base_right, base_bottom,
  // cut_left, cut_top, cut_right, cut_bottom
  input  logic [8*COORD_BITS-1:0]          in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // piece_left, piece_top, piece_right, piece_bottom, zero fill
  output logic [((4*COORD_BITS+7)/8)*8-1:0] out_tdata,
  output logic                             out_tlast
);

  localparam int CB      = COORD_BITS;
  localparam int OUT_W   = ((4*COORD_BITS+7)/8)*8;
  localparam int OUT_PAD = OUT_W - 4*COORD_BITS;

  rsb_pkg::rsb_ctrl_t   ctrl;
  logic                 emit_ready;
  logic signed [CB-1:0] g_left, g_top, g_right, g_bottom, g_end1, g_end2;
  logic signed [CB-1:0] g_row1, g_row2, g_cut_l, g_cut_r;
  logic signed [CB-1:0] piece_left, piece_top, piece_right, piece_bottom;

  rsb_bands #(
    .COORD_BITS(COORD_BITS)
  ) u_bands (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .base_left  (in_tdata[0*CB +: CB]),
    .base_top   (in_tdata[1*CB +: CB]),
    .base_right (in_tdata[2*CB +: CB]),
    .base_bottom(in_tdata[3*CB +: CB]),
    .cut_left   (in_tdata[4*CB +: CB]),
    .cut_top    (in_tdata[5*CB +: CB]),
    .cut_right  (in_tdata[6*CB +: CB]),
    .cut_bottom (in_tdata[7*CB +: CB]),
    .ctrl       (ctrl),
    .out_ready  (emit_ready),
    .g_left     (g_left),
    .g_top      (g_top),
    .g_right    (g_right),
    .g_bottom   (g_bottom),
    .g_end1     (g_end1),
    .g_end2     (g_end2),
    .g_row1     (g_row1),
    .g_row2     (g_row2),
    .g_cut_l    (g_cut_l),
    .g_cut_r    (g_cut_r)
  );

  rsb_emit #(
    .COORD_BITS(COORD_BITS)
  ) u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .in_ready    (emit_ready),
    .g_left      (g_left),
    .g_top       (g_top),
    .g_right     (g_right),
    .g_bottom    (g_bottom),
    .g_end1      (g_end1),
    .g_end2      (g_end2),
    .g_row1      (g_row1),
    .g_row2      (g_row2),
    .g_cut_l     (g_cut_l),
    .g_cut_r     (g_cut_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .piece_left  (piece_left),
    .piece_top   (piece_top),
    .piece_right (piece_right),
    .piece_bottom(piece_bottom),
    .piece_last  (out_tlast)
  );

  generate
    if (OUT_PAD > 0) begin : g_pad
      assign out_tdata = {{OUT_PAD{1'b0}}, piece_bottom, piece_right, piece_top, piece_left};
    end else begin : g_nopad
      assign out_tdata = {piece_bottom, piece_right, piece_top, piece_left};
    end
  endgenerate

  `RSB_ASSERT_SAME(a_pieces_need_wide_base, ctrl.valid && (|ctrl.mask), g_left < g_right)
  `RSB_ASSERT_NEXT(a_stalled_stage_holds, ctrl.valid && !emit_ready, ctrl.valid)
  `RSB_ASSERT_NEXT(a_pieces_stream_on, out_tvalid && out_tready && !out_tlast, out_tvalid)

endmodule
